@@ hdl/fmdc_pkg.sv @@
// Shared types, state codes and filter coefficient tables for the FM demodulation chain.
package fmdc_pkg;

  localparam int COEF_W    = 18;
  localparam int KEPT_BITS = 18;
  localparam int TABLE_LEN = 64;
  localparam int HALF_LEN  = 32;

  localparam int LP_HALF [HALF_LEN] = '{
    -75, -29, 33, 104, 170, 207, 185, 83,
    -100, -332, -544, -648, -562, -242, 284, 903,
    1432, 1658, 1402, 592, -684, -2161, -3426, -3999,
    -3447, -1505, 1829, 6250, 11182, 15872, 19544, 21560
  };

  localparam int AU_HALF [HALF_LEN] = '{
    -48, -18, 20, 67, 124, 191, 258, 315,
    346, 332, 256, 105, -124, -425, -775, -1138,
    -1464, -1695, -1767, -1618, -1199, -478, 555, 1879,
    3446, 5179, 6978, 8729, 10313, 11618, 12546, 13029
  };

  typedef enum logic [1:0] {
    SRC_RE  = 2'd0,
    SRC_IM  = 2'd1,
    SRC_AU  = 2'd2,
    SRC_DIR = 2'd3
  } mac_src_t;

  typedef struct packed {
    logic     valid;
    logic     dst;
    logic     sub;
    mac_src_t src;
  } mac_ctl_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FIR1 = 9'b000000010,
    S_RND1 = 9'b000000100,
    S_DISC = 9'b000001000,
    S_DCHK = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_DFIN = 9'b001000000,
    S_FIR2 = 9'b010000000,
    S_RND2 = 9'b100000000
  } state_t;

  function automatic logic signed [COEF_W-1:0] lp_coef(input logic [7:0] k);
    logic [7:0] j;
    j = (k < 8'(HALF_LEN)) ? k : 8'(TABLE_LEN - 1) - k;
    if (k >= 8'(TABLE_LEN)) return '0;
    return COEF_W'(LP_HALF[j[4:0]]);
  endfunction

  function automatic logic signed [COEF_W-1:0] au_coef(input logic [7:0] k);
    logic [7:0] j;
    j = (k < 8'(HALF_LEN)) ? k : 8'(TABLE_LEN - 1) - k;
    if (k >= 8'(TABLE_LEN)) return '0;
    return COEF_W'(AU_HALF[j[4:0]]);
  endfunction

endpackage

@@ hdl/fm_demodulation_chain_top.sv @@
// FM demodulation chain: decimating IQ low-pass, quadrature discriminator and audio filter.
module fm_demodulation_chain_top #(
  parameter int COMPLEX_TAPS      = 64,
  parameter int AUDIO_TAPS        = 64,
  parameter int FIRST_DECIMATION  = 10,
  parameter int SECOND_DECIMATION = 5,
  parameter int SAMPLE_BITS       = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_real,
  input  logic signed [SAMPLE_BITS-1:0] in_imag,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_demod_sample
);
  // Each accepted IQ word is stored in a circular history memory. A word that the
  // first decimator drops leaves the sequencer idle, so such words stream in
  // back to back. A kept word starts the sequencer: one shared multiplier with a
  // three-stage read/multiply/accumulate pipeline runs the complex low-pass filter
  // (two multiplier passes per tap, real then imaginary), rounds the result, forms
  // the discriminator numerator and denominator in four multiplier passes, then a
  // restoring divider takes one quotient bit per cycle. When the second decimator
  // emits, the audio filter runs through the same multiplier. The in_ready signal
  // is low while a kept word is in work. The output word sits in a register, so the
  // chain continues while the consumer stalls, except that a new audio result waits
  // until the previous one is taken. Filter histories read as zero until written,
  // tracked by fill counters, so no clearing pass is needed after reset.
  import fmdc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int KW1   = $clog2(COMPLEX_TAPS);
  localparam int KW2   = $clog2(AUDIO_TAPS);
  localparam int KWM   = (KW1 > KW2) ? KW1 : KW2;
  localparam int FW1   = $clog2(COMPLEX_TAPS + 1);
  localparam int FW2   = $clog2(AUDIO_TAPS + 1);
  localparam int P1W   = (FIRST_DECIMATION > 1) ? $clog2(FIRST_DECIMATION) : 1;
  localparam int P2W   = (SECOND_DECIMATION > 1) ? $clog2(SECOND_DECIMATION) : 1;
  localparam int A_W   = (SB > KEPT_BITS + 1) ? SB : KEPT_BITS + 1;
  localparam int P_W   = A_W + COEF_W;
  localparam int ACC_W = P_W + 8;
  localparam int REM_W = ACC_W + SB;
  localparam int DCW   = $clog2(SB);

  localparam logic signed [ACC_W-1:0] HALF1  = ACC_W'(1) <<< (SB - 1);
  localparam logic signed [ACC_W-1:0] HALF2  = ACC_W'(1) <<< (COEF_W - 2);
  localparam logic signed [ACC_W-1:0] K_MAX  = ACC_W'((1 << (KEPT_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] K_MIN  = -K_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'((1 << (SB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN  = -Y_MAX - ACC_W'(1);
  localparam logic [SB-1:0]           Q_HALF = SB'(1) << (SB - 1);

  // History memories.
  logic signed [SB-1:0] mem_re [COMPLEX_TAPS];
  logic signed [SB-1:0] mem_im [COMPLEX_TAPS];
  logic signed [SB-1:0] mem_au [AUDIO_TAPS];

  state_t state_r, state_nxt;
  logic [KW1-1:0] ptr1_r, ptr1_nxt, rp1_r, rp1_nxt;
  logic [KW2-1:0] ptr2_r, ptr2_nxt, rp2_r, rp2_nxt;
  logic [FW1-1:0] fill1_r, fill1_nxt;
  logic [FW2-1:0] fill2_r, fill2_nxt;
  logic [P1W-1:0] ph1_r, ph1_nxt, ph1_eff;
  logic [P2W-1:0] ph2_r, ph2_nxt;
  logic [KWM-1:0] k_r, k_nxt;
  logic           rail_r, rail_nxt;
  logic           issue_r, issue_nxt;
  logic [1:0]     step_r, step_nxt;

  logic signed [KEPT_BITS-1:0] kr_r, kr_nxt, ki_r, ki_nxt;
  logic signed [KEPT_BITS-1:0] prev_re_r, prev_re_nxt, prev_im_r, prev_im_nxt;
  logic signed [KEPT_BITS:0]   di, dq;

  // Multiply-accumulate pipeline.
  mac_ctl_t                 ctl1_r, ctl1_nxt, ctl2_r;
  logic signed [COEF_W-1:0] coef_r, coef_nxt, dir_b_r, dir_b_nxt;
  logic signed [A_W-1:0]    dir_a_r, dir_a_nxt, op_a;
  logic signed [COEF_W-1:0] op_b;
  logic                     tapok_r, tapok_nxt;
  logic signed [SB-1:0]     rd_re_r, rd_im_r, rd_au_r;
  logic signed [P_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]  acc0_r, acc0_nxt, acc1_r, acc1_nxt, pext;

  // Divider.
  logic [REM_W-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt, rem_init, den_top;
  logic [ACC_W-1:0] num_mag;
  logic [SB-1:0]    q_r, q_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic             neg_r, neg_nxt, sat_r, sat_nxt, qbit;
  logic signed [SB-1:0] d_val;

  logic signed [ACC_W-1:0] t_re, t_im, t_y;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]    out_data_r, out_data_nxt;
  logic                    wr1_en, wr2_en, accept, emit;

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_demod_sample = out_data_r;

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      mem_re[ptr1_nxt] <= in_real;
      mem_im[ptr1_nxt] <= in_imag;
    end
    rd_re_r <= mem_re[rp1_r];
    rd_im_r <= mem_im[rp1_r];
  end

  always_ff @(posedge clk) begin
    if (wr2_en) begin
      mem_au[ptr2_nxt] <= d_val;
    end
    rd_au_r <= mem_au[rp2_r];
  end

  // Operand selection, then the shared multiplier.
  always_comb begin
    case (ctl1_r.src)
      SRC_RE:  op_a = tapok_r ? A_W'(rd_re_r) : '0;
      SRC_IM:  op_a = tapok_r ? A_W'(rd_im_r) : '0;
      SRC_AU:  op_a = tapok_r ? A_W'(rd_au_r) : '0;
      SRC_DIR: op_a = dir_a_r;
      default: op_a = '0;
    endcase
    op_b = (ctl1_r.src == SRC_DIR) ? dir_b_r : coef_r;
  end

  assign pext = ACC_W'(prod_r);
  assign di   = (KEPT_BITS + 1)'(kr_r) - (KEPT_BITS + 1)'(prev_re_r);
  assign dq   = (KEPT_BITS + 1)'(ki_r) - (KEPT_BITS + 1)'(prev_im_r);
  assign t_re = (acc0_r + HALF1) >>> SB;
  assign t_im = (acc1_r + HALF1) >>> SB;
  assign t_y  = (acc0_r + HALF2) >>> (COEF_W - 1);

  assign num_mag  = acc0_r[ACC_W-1] ? ACC_W'(-acc0_r) : ACC_W'(acc0_r);
  assign rem_init = REM_W'(num_mag) << (SB - 3);
  assign den_top  = REM_W'(acc1_r) << SB;
  assign qbit     = (rem_r >= dsh_r);

  // Signed, saturated quotient.
  always_comb begin
    if (neg_r) begin
      d_val = (sat_r || (q_r > Q_HALF)) ? SB'(Y_MIN) : SB'('0 - q_r);
    end else begin
      d_val = (sat_r || q_r[SB-1]) ? SB'(Y_MAX) : SB'(q_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ptr1_nxt      = ptr1_r;
    ptr2_nxt      = ptr2_r;
    rp1_nxt       = rp1_r;
    rp2_nxt       = rp2_r;
    fill1_nxt     = fill1_r;
    fill2_nxt     = fill2_r;
    ph1_nxt       = ph1_r;
    ph2_nxt       = ph2_r;
    ph1_eff       = ph1_r;
    k_nxt         = k_r;
    rail_nxt      = rail_r;
    issue_nxt     = issue_r;
    step_nxt      = step_r;
    kr_nxt        = kr_r;
    ki_nxt        = ki_r;
    prev_re_nxt   = prev_re_r;
    prev_im_nxt   = prev_im_r;
    ctl1_nxt      = '0;
    coef_nxt      = coef_r;
    tapok_nxt     = tapok_r;
    dir_a_nxt     = dir_a_r;
    dir_b_nxt     = dir_b_r;
    acc0_nxt      = acc0_r;
    acc1_nxt      = acc1_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr1_en        = 1'b0;
    wr2_en        = 1'b0;
    emit          = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Accumulate stage.
    if (ctl2_r.valid) begin
      if (ctl2_r.dst) begin
        acc1_nxt = ctl2_r.sub ? acc1_r - pext : acc1_r + pext;
      end else begin
        acc0_nxt = ctl2_r.sub ? acc0_r - pext : acc0_r + pext;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_frame_start) begin
            ph1_eff = '0;
            ph2_nxt = '0;
          end
          ph1_nxt  = (32'(ph1_eff) + 1 >= FIRST_DECIMATION) ? '0 : ph1_eff + 1'b1;
          ptr1_nxt = (32'(ptr1_r) == COMPLEX_TAPS - 1) ? '0 : ptr1_r + 1'b1;
          wr1_en   = 1'b1;
          if (32'(fill1_r) < COMPLEX_TAPS) fill1_nxt = fill1_r + 1'b1;
          if (ph1_eff == '0) begin
            state_nxt = S_FIR1;
            issue_nxt = 1'b1;
            rail_nxt  = 1'b0;
            k_nxt     = '0;
            rp1_nxt   = ptr1_nxt;
            acc0_nxt  = '0;
            acc1_nxt  = '0;
          end
        end
      end
      S_FIR1: begin
        if (issue_r) begin
          ctl1_nxt  = '{valid: 1'b1, dst: rail_r, sub: 1'b0,
                        src: rail_r ? SRC_IM : SRC_RE};
          coef_nxt  = lp_coef(8'(k_r));
          tapok_nxt = (32'(k_r) < 32'(fill1_r));
          rail_nxt  = !rail_r;
          if (rail_r) begin
            k_nxt   = k_r + 1'b1;
            rp1_nxt = (rp1_r == '0) ? KW1'(COMPLEX_TAPS - 1) : rp1_r - 1'b1;
            if (32'(k_r) == COMPLEX_TAPS - 1) issue_nxt = 1'b0;
          end
        end else if (!ctl1_r.valid && !ctl2_r.valid) begin
          state_nxt = S_RND1;
        end
      end
      S_RND1: begin
        kr_nxt = (t_re > K_MAX) ? KEPT_BITS'(K_MAX) :
                 (t_re < K_MIN) ? KEPT_BITS'(K_MIN) : KEPT_BITS'(t_re);
        ki_nxt = (t_im > K_MAX) ? KEPT_BITS'(K_MAX) :
                 (t_im < K_MIN) ? KEPT_BITS'(K_MIN) : KEPT_BITS'(t_im);
        state_nxt = S_DISC;
        issue_nxt = 1'b1;
        step_nxt  = '0;
        acc0_nxt  = '0;
        acc1_nxt  = '0;
      end
      S_DISC: begin
        if (issue_r) begin
          ctl1_nxt = '{valid: 1'b1, dst: step_r[1], sub: (step_r == 2'd1), src: SRC_DIR};
          case (step_r)
            2'd0: begin
              dir_a_nxt = A_W'(dq);
              dir_b_nxt = kr_r;
            end
            2'd1: begin
              dir_a_nxt = A_W'(di);
              dir_b_nxt = ki_r;
            end
            2'd2: begin
              dir_a_nxt = A_W'(kr_r);
              dir_b_nxt = kr_r;
            end
            default: begin
              dir_a_nxt = A_W'(ki_r);
              dir_b_nxt = ki_r;
            end
          endcase
          step_nxt = step_r + 1'b1;
          if (step_r == 2'd3) issue_nxt = 1'b0;
        end else if (!ctl1_r.valid && !ctl2_r.valid) begin
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        q_nxt = '0;
        if (acc1_r == '0) begin
          neg_nxt   = 1'b0;
          sat_nxt   = 1'b0;
          state_nxt = S_DFIN;
        end else begin
          neg_nxt = acc0_r[ACC_W-1];
          rem_nxt = rem_init;
          dsh_nxt = den_top >> 1;
          sat_nxt = (rem_init >= den_top);
          dcnt_nxt = DCW'(SB - 1);
          state_nxt = (rem_init >= den_top) ? S_DFIN : S_DIV;
        end
      end
      S_DIV: begin
        if (qbit) rem_nxt = rem_r - dsh_r;
        q_nxt    = {q_r[SB-2:0], qbit};
        dsh_nxt  = dsh_r >> 1;
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        prev_re_nxt = kr_r;
        prev_im_nxt = ki_r;
        ptr2_nxt    = (32'(ptr2_r) == AUDIO_TAPS - 1) ? '0 : ptr2_r + 1'b1;
        wr2_en      = 1'b1;
        if (32'(fill2_r) < AUDIO_TAPS) fill2_nxt = fill2_r + 1'b1;
        emit    = (ph2_r == '0);
        ph2_nxt = (32'(ph2_r) + 1 >= SECOND_DECIMATION) ? '0 : ph2_r + 1'b1;
        if (emit) begin
          state_nxt = S_FIR2;
          issue_nxt = 1'b1;
          k_nxt     = '0;
          rp2_nxt   = ptr2_nxt;
          acc0_nxt  = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIR2: begin
        if (issue_r) begin
          ctl1_nxt  = '{valid: 1'b1, dst: 1'b0, sub: 1'b0, src: SRC_AU};
          coef_nxt  = au_coef(8'(k_r));
          tapok_nxt = (32'(k_r) < 32'(fill2_r));
          k_nxt     = k_r + 1'b1;
          rp2_nxt   = (rp2_r == '0) ? KW2'(AUDIO_TAPS - 1) : rp2_r - 1'b1;
          if (32'(k_r) == AUDIO_TAPS - 1) issue_nxt = 1'b0;
        end else if (!ctl1_r.valid && !ctl2_r.valid) begin
          state_nxt = S_RND2;
        end
      end
      S_RND2: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = (t_y > Y_MAX) ? SB'(Y_MAX) :
                          (t_y < Y_MIN) ? SB'(Y_MIN) : SB'(t_y);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr1_r      <= '0;
      ptr2_r      <= '0;
      fill1_r     <= '0;
      fill2_r     <= '0;
      ph1_r       <= '0;
      ph2_r       <= '0;
      prev_re_r   <= '0;
      prev_im_r   <= '0;
      issue_r     <= 1'b0;
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr1_r      <= ptr1_nxt;
      ptr2_r      <= ptr2_nxt;
      fill1_r     <= fill1_nxt;
      fill2_r     <= fill2_nxt;
      ph1_r       <= ph1_nxt;
      ph2_r       <= ph2_nxt;
      prev_re_r   <= prev_re_nxt;
      prev_im_r   <= prev_im_nxt;
      issue_r     <= issue_nxt;
      ctl1_r      <= ctl1_nxt;
      ctl2_r      <= ctl1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp1_r      <= rp1_nxt;
    rp2_r      <= rp2_nxt;
    k_r        <= k_nxt;
    rail_r     <= rail_nxt;
    step_r     <= step_nxt;
    kr_r       <= kr_nxt;
    ki_r       <= ki_nxt;
    coef_r     <= coef_nxt;
    tapok_r    <= tapok_nxt;
    dir_a_r    <= dir_a_nxt;
    dir_b_r    <= dir_b_nxt;
    prod_r     <= op_a * op_b;
    acc0_r     <= acc0_nxt;
    acc1_r     <= acc1_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    neg_r      <= neg_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl1_r.valid |-> (state_r == S_FIR1 || state_r == S_DISC || state_r == S_FIR2))
    else $error("multiplier pipeline busy outside a filter or discriminator run");
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!ctl1_r.valid && !ctl2_r.valid && !issue_r))
    else $error("sequencer idle with work left in the pipeline");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fill1_r) <= COMPLEX_TAPS) && (32'(fill2_r) <= AUDIO_TAPS))
    else $error("history fill count beyond filter length");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (32'(dcnt_r) < SB))
    else $error("divider bit counter out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND2 && out_valid_r && !out_ready) |=> (state_r == S_RND2))
    else $error("audio result left before the output register was free");
`endif

endmodule

@@ sim/fm_demodulation_chain_checker.sv @@
// Checker for the FM demodulation chain: predicts audio words and compares them at the output.
`timescale 1ns / 100ps
module fm_demodulation_chain_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_real,
  input  logic signed [15:0] in_imag,
  input  logic               in_frame_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_demod_sample,
  output int                 fail_count,
  output int                 pending_audio,
  output int                 audio_seen
);
  import fmdc_pkg::*;

  longint iq_hist_re [64];
  longint iq_hist_im [64];
  longint disc_hist [64];
  int     keep_phase;
  int     emit_phase;
  longint last_re;
  longint last_im;
  logic signed [15:0] audio_expected [$];

  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint lp_tap(int k);
    return LP_HALF[k < HALF_LEN ? k : TABLE_LEN - 1 - k];
  endfunction

  function automatic longint au_tap(int k);
    return AU_HALF[k < HALF_LEN ? k : TABLE_LEN - 1 - k];
  endfunction

  // Advances the predicted chain by one sample and queues an audio word when one is due.
  task automatic demodulate_sample(logic signed [15:0] re, logic signed [15:0] im, logic fs);
    longint acc_re;
    longint acc_im;
    longint kr;
    longint ki;
    longint num;
    longint den;
    longint d;
    longint acc;
    logic   emit;
    acc_re = 0;
    acc_im = 0;
    acc = 0;
    d = 0;
    if (fs) begin
      keep_phase = 0;
      emit_phase = 0;
    end
    for (int k = 63; k > 0; k--) begin
      iq_hist_re[k] = iq_hist_re[k-1];
      iq_hist_im[k] = iq_hist_im[k-1];
    end
    iq_hist_re[0] = re;
    iq_hist_im[0] = im;
    for (int k = 0; k < 64; k++) begin
      acc_re += lp_tap(k) * iq_hist_re[k];
      acc_im += lp_tap(k) * iq_hist_im[k];
    end
    if (keep_phase != 0) begin
      keep_phase = (keep_phase + 1 >= 10) ? 0 : keep_phase + 1;
      return;
    end
    keep_phase = 1;
    kr = clamp(floor_div_pow2(acc_re + (longint'(1) <<< 15), 16), 18);
    ki = clamp(floor_div_pow2(acc_im + (longint'(1) <<< 15), 16), 18);
    num = kr * (ki - last_im) - ki * (kr - last_re);
    den = kr * kr + ki * ki;
    if (den != 0) d = clamp((num * 8192) / den, 16);
    last_re = kr;
    last_im = ki;
    for (int k = 63; k > 0; k--) disc_hist[k] = disc_hist[k-1];
    disc_hist[0] = d;
    emit = (emit_phase == 0);
    emit_phase = (emit_phase + 1 >= 5) ? 0 : emit_phase + 1;
    if (!emit) return;
    for (int k = 0; k < 64; k++) acc += au_tap(k) * disc_hist[k];
    audio_expected.push_back(16'(clamp(floor_div_pow2(acc + (longint'(1) <<< 16), 17), 16)));
  endtask

  assign pending_audio = audio_expected.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 64; k++) begin
        iq_hist_re[k] = 0;
        iq_hist_im[k] = 0;
        disc_hist[k] = 0;
      end
      keep_phase = 0;
      emit_phase = 0;
      last_re = 0;
      last_im = 0;
      audio_expected.delete();
      fail_count <= 0;
      audio_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        audio_seen <= audio_seen + 1;
        if (audio_expected.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected audio word %0d", out_demod_sample);
        end else begin
          if (out_demod_sample !== audio_expected[0]) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("audio mismatch: expected %0d, got %0d", audio_expected[0],
                       out_demod_sample);
          end
          void'(audio_expected.pop_front());
        end
      end
      if (in_valid && in_ready) demodulate_sample(in_real, in_imag, in_frame_start);
    end
  end
endmodule

@@ sim/fm_demodulation_chain_top_test.sv @@
// Testbench top for the FM demodulation chain: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module fm_demodulation_chain_top_test;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_real;
  logic signed [15:0] in_imag;
  logic               in_frame_start;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_demod_sample;
  int                 fail_count;
  int                 pending_audio;
  int                 audio_seen;
  int                 quiet_cycles;
  int                 samples_sent;
  bit                 long_hold;
  bit                 hold_done;

  fm_demodulation_chain_top dut (.*);

  fm_demodulation_chain_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which neither channel moves a word. The longest quiet
  // stretch in a correct run is the receiver's long hold-off, so this limit is generous.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("fm_demodulation_chain_top verification failed");
      $finish;
    end
  end

  // Sends one word, after a random gap, and waits until the block takes it. Valid stays
  // high after the handshake so that a word without a gap follows directly.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic fs,
                             bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_real <= re;
    in_imag <= im;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // The receiver draws a fresh stall for every word; one long hold-off lets the block
  // fill up so that its input side must stall while samples keep coming.
  initial begin
    int stall;
    out_ready <= 0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready) && !long_hold);
    end
  end

  initial begin
    int   tone_step;
    int   angle;
    int   amp;
    int   burst;
    bit   no_gap;
    real  ph;
    rst_n <= 0;
    in_valid <= 0;
    in_real <= 0;
    in_imag <= 0;
    in_frame_start <= 0;
    samples_sent = 0;
    long_hold = 0;
    hold_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: zero magnitude, full-scale corners to drive every stage into
    // saturation, and a frame start in the middle of a decimation period.
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 1, 0);
    send_sample(16'sh7fff, 16'sh7fff, 0, 0);
    send_sample(-16'sh8000, -16'sh8000, 0, 0);
    send_sample(16'sh7fff, -16'sh8000, 0, 0);
    send_sample(-16'sh8000, 16'sh7fff, 0, 1);
    send_sample(16'sh5555, -16'sh2aab, 1, 0);
    for (int i = 0; i < 14; i++)
      send_sample((i % 2) ? -16'sh8000 : 16'sh7fff, (i % 3) ? 16'sh7fff : -16'sh8000,
                  i == 9, (i % 2) == 1);

    // Random part: mostly FM tones of random rate and amplitude so the discriminator
    // sees smooth phase rotation; the rest is raw noise with occasional frame starts.
    while (samples_sent < 1300) begin
      burst = $urandom_range(20, 120);
      if (samples_sent > 600 && !hold_done) begin
        long_hold = 1;
        hold_done = 1;
      end
      if ($urandom_range(0, 3) != 0) begin
        tone_step = $urandom_range(0, 400);
        amp = $urandom_range(100, 32767);
        angle = 0;
        for (int i = 0; i < burst; i++) begin
          ph = angle * 3.14159265 / 1000.0;
          angle += tone_step - 200;
          no_gap = ($urandom_range(0, 4) == 0);
          send_sample(16'($rtoi(amp * $cos(ph))), 16'($rtoi(amp * $sin(ph))),
                      $urandom_range(0, 199) == 0, no_gap);
        end
      end else begin
        for (int i = 0; i < burst; i++)
          send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 29) == 0,
                      $urandom_range(0, 2) == 0);
      end
    end
    in_valid <= 0;

    while (pending_audio != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d IQ samples with tones, noise, corners and frame starts;", samples_sent);
    $display("checked %0d audio words including a long output hold-off.", audio_seen);
    if (fail_count == 0) $display("fm_demodulation_chain_top verification clean");
    else $display("fm_demodulation_chain_top verification failed");
    $finish;
  end
endmodule
